>>> sv/mfcl_pkg.sv
package mfcl_pkg;

    localparam int HIST_DEPTH = 64;
    localparam int HIST_AW    = (HIST_DEPTH > 1) ? $clog2(HIST_DEPTH) : 1;
    localparam int HELD_W     = $clog2(HIST_DEPTH + 1);

    localparam int CMD_W      = 2;
    localparam int FC_W       = 16;
    localparam int LEN_W      = 12;
    localparam int MAC_W      = 48;
    localparam int RSSI_W     = 8;
    localparam int CHAN_W     = 4;
    localparam int IDX_W      = 6;
    localparam int STATUS_W   = 3;
    localparam int CLASS_W    = 2;
    localparam int COUNT_W    = 7;
    localparam int DROP_W     = 32;
    localparam int FREQ_W     = 12;
    localparam int ENTRY_W    = MAC_W + RSSI_W + CHAN_W + CLASS_W;

    localparam int S_TDATA_W  = 96;
    localparam int S_TUSER_W  = 3;
    localparam int M_TDATA_W  = 120;
    localparam int M_TUSER_W  = 5;

    localparam logic [CMD_W-1:0] CMD_CAPTURE = 2'd0;
    localparam logic [CMD_W-1:0] CMD_READ    = 2'd1;
    localparam logic [CMD_W-1:0] CMD_CLEAR   = 2'd2;

    localparam logic [STATUS_W-1:0] ST_STORED   = 3'd0;
    localparam logic [STATUS_W-1:0] ST_REJECTED = 3'd1;
    localparam logic [STATUS_W-1:0] ST_IGNORED  = 3'd2;
    localparam logic [STATUS_W-1:0] ST_DROPPED  = 3'd3;
    localparam logic [STATUS_W-1:0] ST_DONE     = 3'd4;

    localparam logic [CLASS_W-1:0] CLS_PROBE_REQ  = 2'd0;
    localparam logic [CLASS_W-1:0] CLS_PROBE_RESP = 2'd1;
    localparam logic [CLASS_W-1:0] CLS_BEACON     = 2'd2;
    localparam logic [CLASS_W-1:0] CLS_NONE       = 2'd3;

    localparam logic [3:0] SUB_PROBE_REQ  = 4'd4;
    localparam logic [3:0] SUB_PROBE_RESP = 4'd5;
    localparam logic [3:0] SUB_BEACON     = 4'd8;
    localparam logic [LEN_W-1:0] MIN_FRAME_LEN = 12'd24;

    localparam logic [FREQ_W-1:0] FREQ_BASE  = 12'd2407;
    localparam logic [FREQ_W-1:0] FREQ_CH14  = 12'd2484;
    localparam logic [CHAN_W-1:0] CHAN_LAST  = 4'd13;
    localparam logic [CHAN_W-1:0] CHAN_JAPAN = 4'd14;

    // Command from the controller to the datapath.
    typedef struct packed {
        logic exec;
    } mfcl_cmd_t;

endpackage

>>> sv/mfcl_ctrl.sv
module mfcl_ctrl
    import mfcl_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output mfcl_cmd_t  cmd
);

    typedef enum logic {
        S_IDLE,
        S_RESP
    } state_t;

    state_t state_reg;
    logic   ready_reg;
    logic   valid_reg;

    assign s_axis_tready = ready_reg;
    assign m_axis_tvalid = valid_reg;
    assign cmd.exec      = s_axis_tvalid & ready_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            ready_reg <= 1'b0;
            valid_reg <= 1'b0;
        end
        else
        begin
            case (state_reg)
                S_IDLE:
                begin
                    if (s_axis_tvalid && ready_reg)
                    begin
                        state_reg <= S_RESP;
                        ready_reg <= 1'b0;
                        valid_reg <= 1'b1;
                    end
                    else
                    begin
                        ready_reg <= 1'b1;
                    end
                end
                S_RESP:
                begin
                    if (m_axis_tready)
                    begin
                        state_reg <= S_IDLE;
                        ready_reg <= 1'b1;
                        valid_reg <= 1'b0;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                    ready_reg <= 1'b0;
                    valid_reg <= 1'b0;
                end
            endcase
        end
    end

endmodule

>>> sv/mfcl_datapath.sv
module mfcl_datapath
    import mfcl_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  mfcl_cmd_t           cmd,
    input  logic [CMD_W-1:0]    command,
    input  logic [FC_W-1:0]     frame_control,
    input  logic [LEN_W-1:0]    frame_length,
    input  logic [MAC_W-1:0]    tx_addr,
    input  logic signed [RSSI_W-1:0] signal_strength,
    input  logic [CHAN_W-1:0]   radio_channel,
    input  logic                is_management,
    input  logic [IDX_W-1:0]    read_index,
    output logic [STATUS_W-1:0] status,
    output logic [CLASS_W-1:0]  frame_class,
    output logic [COUNT_W-1:0]  sample_count,
    output logic [DROP_W-1:0]   dropped_count,
    output logic                entry_valid,
    output logic [MAC_W-1:0]    entry_mac,
    output logic signed [RSSI_W-1:0] entry_rssi,
    output logic [CHAN_W-1:0]   entry_channel,
    output logic [CLASS_W-1:0]  entry_class,
    output logic [FREQ_W-1:0]   entry_frequency
);

    localparam int CMP_W = ((HIST_AW > IDX_W) ? HIST_AW : IDX_W) + 2;

    logic [ENTRY_W-1:0] mem [HIST_DEPTH];
    logic [ENTRY_W-1:0] rd_data_reg;

    logic [HIST_AW-1:0]  head_reg, head_next;
    logic [HELD_W-1:0]   held_reg, held_next;
    logic [DROP_W-1:0]   drops_reg, drops_next;
    logic [STATUS_W-1:0] status_reg, status_next;
    logic [CLASS_W-1:0]  class_reg;
    logic                valid_reg, valid_next;

    logic [CLASS_W-1:0]  cls;
    logic                addr_ignored;
    logic [HIST_AW-1:0]  head_dec;
    logic [CMP_W-1:0]    addr_sum;
    logic [HIST_AW-1:0]  rd_addr;
    logic                wr_en;
    logic                rd_en;

    always_comb
    begin
        cls = CLS_NONE;
        if (is_management && (frame_length >= MIN_FRAME_LEN)
            && (frame_control[3:2] == 2'b00))
        begin
            case (frame_control[7:4])
                SUB_PROBE_REQ:  cls = CLS_PROBE_REQ;
                SUB_PROBE_RESP: cls = CLS_PROBE_RESP;
                SUB_BEACON:     cls = CLS_BEACON;
                default:        cls = CLS_NONE;
            endcase
        end
    end

    // Zero, broadcast and group addresses (group bit of the first byte).
    assign addr_ignored = (tx_addr == '0) || (&tx_addr) || tx_addr[40];

    // The newest entry sits at head; a store moves head back one place.
    assign head_dec = (head_reg == '0) ? HIST_AW'(HIST_DEPTH - 1) : head_reg - 1'b1;

    always_comb
    begin
        addr_sum = CMP_W'(head_reg) + CMP_W'(read_index);
        if (addr_sum >= CMP_W'(HIST_DEPTH))
        begin
            addr_sum = addr_sum - CMP_W'(HIST_DEPTH);
        end
        rd_addr = addr_sum[HIST_AW-1:0];
    end

    always_comb
    begin
        head_next   = head_reg;
        held_next   = held_reg;
        drops_next  = drops_reg;
        status_next = ST_DONE;
        valid_next  = 1'b0;
        wr_en       = 1'b0;
        rd_en       = 1'b0;
        case (command)
            CMD_CAPTURE:
            begin
                if (cls == CLS_NONE)
                begin
                    status_next = ST_REJECTED;
                end
                else if (addr_ignored)
                begin
                    status_next = ST_IGNORED;
                end
                else if (held_reg == HELD_W'(HIST_DEPTH))
                begin
                    status_next = ST_DROPPED;
                    if (!(&drops_reg))
                    begin
                        drops_next = drops_reg + 1'b1;
                    end
                end
                else
                begin
                    status_next = ST_STORED;
                    head_next   = head_dec;
                    held_next   = held_reg + 1'b1;
                    wr_en       = cmd.exec;
                end
            end
            CMD_READ:
            begin
                valid_next = (CMP_W'(read_index) < CMP_W'(held_reg));
                rd_en      = cmd.exec;
            end
            CMD_CLEAR:
            begin
                held_next  = '0;
                drops_next = '0;
            end
            default:
            begin
                status_next = ST_DONE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            held_reg  <= '0;
            drops_reg <= '0;
        end
        else if (cmd.exec)
        begin
            head_reg  <= head_next;
            held_reg  <= held_next;
            drops_reg <= drops_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.exec)
        begin
            status_reg <= status_next;
            class_reg  <= (command == CMD_CAPTURE) ? cls : CLS_NONE;
            valid_reg  <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[head_dec] <= {tx_addr, signal_strength, radio_channel, cls};
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    logic [CHAN_W-1:0] rd_chan;
    assign rd_chan = rd_data_reg[CLASS_W +: CHAN_W];

    always_comb
    begin
        entry_mac       = '0;
        entry_rssi      = '0;
        entry_channel   = '0;
        entry_class     = '0;
        entry_frequency = '0;
        if (valid_reg)
        begin
            entry_mac     = rd_data_reg[ENTRY_W-1 -: MAC_W];
            entry_rssi    = rd_data_reg[CLASS_W+CHAN_W +: RSSI_W];
            entry_channel = rd_chan;
            entry_class   = rd_data_reg[CLASS_W-1:0];
            if ((rd_chan != '0) && (rd_chan <= CHAN_LAST))
            begin
                entry_frequency = FREQ_BASE + FREQ_W'({rd_chan, 2'b00}) + FREQ_W'(rd_chan);
            end
            else if (rd_chan == CHAN_JAPAN)
            begin
                entry_frequency = FREQ_CH14;
            end
        end
    end

    assign status        = status_reg;
    assign frame_class   = class_reg;
    assign sample_count  = COUNT_W'(held_reg);
    assign dropped_count = drops_reg;
    assign entry_valid   = valid_reg;

endmodule

>>> sv/mgmt_frame_capture_log.sv
// Channel  Direction  tdata fields (low bit up)                       tuser fields
// s_axis   in         frame_control, frame_length, tx_addr,           command,
//                     signal_strength, radio_channel, read_index      is_management
// m_axis   out        sample_count, dropped_count, entry_valid,       status,
//                     entry_mac, entry_rssi, entry_channel,           frame_class
//                     entry_class, entry_frequency
//
// Each request is accepted and executed, and its result is registered and then
// presented. The next request is taken only after the result is taken.
// The history read port is registered.
// Reset clears the fill count, drop counter and history pointer; no clearing pass.
// A stalled result holds the block; new requests wait until it is taken.
module mgmt_frame_capture_log
    import mfcl_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    // frame_control[15:0], frame_length[27:16], tx_addr[75:28],
    // signal_strength[83:76], radio_channel[87:84], read_index[93:88], zero fill
    input  logic [S_TDATA_W-1:0] s_axis_tdata,
    // command[1:0], is_management[2]
    input  logic [S_TUSER_W-1:0] s_axis_tuser,
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    // sample_count[6:0], dropped_count[38:7], entry_valid[39], entry_mac[87:40],
    // entry_rssi[95:88], entry_channel[99:96], entry_class[101:100],
    // entry_frequency[113:102], zero fill
    output logic [M_TDATA_W-1:0] m_axis_tdata,
    // status[2:0], frame_class[4:3]
    output logic [M_TUSER_W-1:0] m_axis_tuser
);

    mfcl_cmd_t cmd;

    logic [STATUS_W-1:0] status;
    logic [CLASS_W-1:0]  frame_class;
    logic [COUNT_W-1:0]  sample_count;
    logic [DROP_W-1:0]   dropped_count;
    logic                entry_valid;
    logic [MAC_W-1:0]    entry_mac;
    logic signed [RSSI_W-1:0] entry_rssi;
    logic [CHAN_W-1:0]   entry_channel;
    logic [CLASS_W-1:0]  entry_class;
    logic [FREQ_W-1:0]   entry_frequency;

    mfcl_ctrl u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .cmd           (cmd)
    );

    mfcl_datapath u_datapath (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .command         (s_axis_tuser[1:0]),
        .frame_control   (s_axis_tdata[15:0]),
        .frame_length    (s_axis_tdata[27:16]),
        .tx_addr         (s_axis_tdata[75:28]),
        .signal_strength (s_axis_tdata[83:76]),
        .radio_channel   (s_axis_tdata[87:84]),
        .is_management   (s_axis_tuser[2]),
        .read_index      (s_axis_tdata[93:88]),
        .status          (status),
        .frame_class     (frame_class),
        .sample_count    (sample_count),
        .dropped_count   (dropped_count),
        .entry_valid     (entry_valid),
        .entry_mac       (entry_mac),
        .entry_rssi      (entry_rssi),
        .entry_channel   (entry_channel),
        .entry_class     (entry_class),
        .entry_frequency (entry_frequency)
    );

    assign m_axis_tdata = {6'b0, entry_frequency, entry_class, entry_channel, entry_rssi,
                           entry_mac, entry_valid, dropped_count, sample_count};
    assign m_axis_tuser = {frame_class, status};

endmodule

>>> sv/mfcl_checker.sv
module mfcl_checker
    import mfcl_pkg::*;
(
    input logic                 clk,
    input logic                 rst_n,
    input logic                 s_axis_tvalid,
    input logic                 s_axis_tready,
    input logic                 m_axis_tvalid,
    input logic                 m_axis_tready,
    input logic [M_TDATA_W-1:0] m_axis_tdata
);

    // Every accepted request yields its result on the next cycle.
    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready) |=> m_axis_tvalid)
        else $error("result not presented after accepted request");

    // Only one request is in flight at a time.
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> !s_axis_tready)
        else $error("request accepted while a result is pending");

    a_valid_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid)
        else $error("result withdrawn before it was taken");

    // Entry fields of a presented result are zero whenever the entry is not valid.
    a_entry_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tdata[39]) |-> (m_axis_tdata[113:40] == '0))
        else $error("entry fields nonzero without a valid entry");

    // No result ever shows a count beyond the history depth.
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tdata[6:0] <= 7'(HIST_DEPTH)))
        else $error("sample count beyond history depth");

endmodule

bind mgmt_frame_capture_log mfcl_checker u_mfcl_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
